// ----- design/mprd_pkg.sv -----
// Package for the multi-priority request deque.
// Holds sizing constants, word types, state codes and the slot address helpers.
// No dependencies.
package mprd_pkg;

	// Sizing of the queue store.
	localparam int PRIORITY_LEVELS = 4;
	localparam int LEVEL_DEPTH     = 16;
	localparam int NUM_SLOTS       = PRIORITY_LEVELS * LEVEL_DEPTH;
	localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int IDX_W  = $clog2(LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_SLOTS);
	localparam int TAG_W  = 16;
	localparam int KEY_W  = 16;
	localparam int SLOT_W = TAG_W + KEY_W;

	// Operation codes carried in the mode field.
	typedef enum logic [1:0] {
		MODE_TAIL   = 2'd0,
		MODE_HEAD   = 2'd1,
		MODE_TAKE   = 2'd2,
		MODE_CANCEL = 2'd3
	} mode_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_EXEC    = 6'b000010,
		S_TAKE_RD = 6'b000100,
		S_CAN_RD  = 6'b001000,
		S_CAN_CMP = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	// Request word.
	typedef struct packed {
		mode_t       mode;
		logic [1:0]  level;
		logic [15:0] request_tag;
		logic [15:0] request_key;
	} req_t;

	// Result word.
	typedef struct packed {
		logic        taken_valid;
		logic [15:0] taken_tag;
		logic [1:0]  taken_level;
		logic [4:0]  removed_count;
		logic        insert_dropped;
		logic        any_queued;
	} res_t;

	// Ring position base + off, where both are below the level depth.
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = (IDX_W+1)'(base) + (IDX_W+1)'(off);
		if (sum >= (IDX_W+1)'(LEVEL_DEPTH)) begin
			sum = sum - (IDX_W+1)'(LEVEL_DEPTH);
		end
		return IDX_W'(sum);
	endfunction

	// Flat store address of a ring position within a level.
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(idx);
	endfunction

endpackage

// ----- design/mprd_req_if.sv -----
// Request channel of the multi-priority request deque.
// Depends on mprd_pkg for the request word type.
interface mprd_req_if;
	import mprd_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mprd_res_if.sv -----
// Result channel of the multi-priority request deque.
// Depends on mprd_pkg for the result word type.
interface mprd_res_if;
	import mprd_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mprd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mprd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- design/multi_priority_request_deque_top.sv -----
// Top level of the multi-priority request deque.
// Depends on mprd_pkg, mprd_req_if, mprd_res_if and mprd_ram.
//
// Usage: one request word enters on req and exactly one result word leaves
// on res for it. Mode tail or head inserts a tag and key into one priority
// level, take pops the head of the lowest-numbered non-empty level, cancel
// removes every entry of a level whose key matches. All slots live in one
// RAM with one write and one registered read port; a small sequencer
// drives the slot address adder and a single key comparator against it.
// From acceptance to result valid, an insert passes S_EXEC and S_DONE, a
// take S_EXEC, S_TAKE_RD and S_DONE (S_EXEC and S_DONE when every level is
// empty), a cancel S_EXEC, S_CAN_RD and S_CAN_CMP once per entry of the
// level, then S_DONE, since each entry needs a read and a compare/write on
// the RAM port. One request is in work at a time; req.ready is high only
// while the sequencer is idle, so with res.ready held high the next request
// can be taken in the same cycle as each result goes valid.
// The result sits in an output register, so a new request is taken while
// an earlier result waits on a stalled res.ready; the sequencer holds its
// finished result until that register frees up.
// Reset clears all level heads and counts (every level empty) and the
// output valid flag; the slot RAM needs no clearing.
module multi_priority_request_deque_top (
	input logic        clk,
	input logic        arst_n,
	mprd_req_if.sink   req,
	mprd_res_if.source res
);
	import mprd_pkg::*;

	state_t            state_q;
	req_t              req_q;
	logic [IDX_W-1:0]  head_q [PRIORITY_LEVELS];
	logic [CNT_W-1:0]  count_q [PRIORITY_LEVELS];
	logic [CNT_W-1:0]  walk_i_q;
	logic [CNT_W-1:0]  kept_q;
	logic [CNT_W-1:0]  removed_q;
	logic              res_valid_q;
	logic [LVL_W-1:0]  res_level_q;
	logic              res_drop_q;
	logic [TAG_W-1:0]  res_tag_q;
	res_t              out_q;
	logic              out_valid_q;

	logic              req_fire;
	logic              out_free;
	logic              is_exec;
	logic [LVL_W-1:0]  lvl;
	logic              lvl_ok;
	logic              ins_ok;
	logic              found;
	logic [LVL_W-1:0]  found_lvl;
	logic [LVL_W-1:0]  op_lvl;
	logic [IDX_W-1:0]  head_dec;
	logic [IDX_W-1:0]  op_base;
	logic [CNT_W-1:0]  op_off;
	logic [IDX_W-1:0]  ring_idx;
	logic [ADDR_W-1:0] slot_a;
	logic              ram_we;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_wdata;
	logic [SLOT_W-1:0] ram_rdata;
	logic              key_match;
	logic              any_queued;
	logic              count_over;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;
	assign is_exec   = (state_q == S_EXEC);

	// Level decode and insert admission.
	assign lvl    = LVL_W'(req_q.level);
	assign lvl_ok = (32'(req_q.level) < PRIORITY_LEVELS);
	assign ins_ok = lvl_ok && (count_q[lvl] < CNT_W'(LEVEL_DEPTH));

	// Lowest-numbered non-empty level, and occupancy summaries.
	always_comb begin
		found      = 1'b0;
		found_lvl  = '0;
		any_queued = 1'b0;
		count_over = 1'b0;
		for (int i = 0; i < PRIORITY_LEVELS; i++) begin
			if (count_q[i] != '0) begin
				any_queued = 1'b1;
				if (!found) begin
					found     = 1'b1;
					found_lvl = LVL_W'(i);
				end
			end
			if (count_q[i] > CNT_W'(LEVEL_DEPTH)) begin
				count_over = 1'b1;
			end
		end
	end

	// Shared slot address unit: base ring position plus offset.
	always_comb begin
		head_dec = (head_q[lvl] == '0) ? IDX_W'(LEVEL_DEPTH - 1) : head_q[lvl] - 1'b1;
		op_lvl   = (is_exec && req_q.mode == MODE_TAKE) ? found_lvl : lvl;
		op_base  = (is_exec && req_q.mode == MODE_HEAD) ? head_dec : head_q[op_lvl];
		if (state_q == S_CAN_CMP) begin
			op_off = kept_q;
		end else if (is_exec && req_q.mode == MODE_TAIL) begin
			op_off = count_q[lvl];
		end else begin
			op_off = walk_i_q;
		end
		ring_idx = ring_add(op_base, op_off);
		slot_a   = slot_addr(op_lvl, ring_idx);
	end

	// RAM port control.
	assign key_match = (ram_rdata[KEY_W-1:0] == req_q.request_key);
	assign ram_we    = (is_exec && (req_q.mode == MODE_TAIL || req_q.mode == MODE_HEAD)
			&& ins_ok) || (state_q == S_CAN_CMP && !key_match);
	assign ram_re    = (is_exec && req_q.mode == MODE_TAKE && found) ||
			(state_q == S_CAN_RD);
	assign ram_wdata = is_exec ? {req_q.request_tag, req_q.request_key} : ram_rdata;

	mprd_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (NUM_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_a),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot_a),
		.rdata (ram_rdata)
	);

	// Sequencer, level bookkeeping and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			walk_i_q    <= '0;
			kept_q      <= '0;
			removed_q   <= '0;
			res_valid_q <= 1'b0;
			res_level_q <= '0;
			res_drop_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PRIORITY_LEVELS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			// A finishing sequencer reloads the output register in S_DONE instead.
			if (out_valid_q && res.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						walk_i_q    <= '0;
						kept_q      <= '0;
						removed_q   <= '0;
						res_valid_q <= 1'b0;
						res_level_q <= '0;
						res_drop_q  <= 1'b0;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q.mode) inside
						MODE_TAIL, MODE_HEAD: begin
							res_drop_q <= !ins_ok;
							if (ins_ok) begin
								count_q[lvl] <= count_q[lvl] + 1'b1;
								if (req_q.mode == MODE_HEAD) begin
									head_q[lvl] <= head_dec;
								end
							end
							state_q <= S_DONE;
						end
						MODE_TAKE: begin
							if (found) begin
								head_q[found_lvl] <= ring_add(head_q[found_lvl], CNT_W'(1));
								count_q[found_lvl] <= count_q[found_lvl] - 1'b1;
								res_valid_q <= 1'b1;
								res_level_q <= found_lvl;
								state_q     <= S_TAKE_RD;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							if (lvl_ok && count_q[lvl] != '0) begin
								state_q <= S_CAN_RD;
							end else begin
								state_q <= S_DONE;
							end
						end
					endcase
				end
				S_TAKE_RD: begin
					state_q <= S_DONE;
				end
				S_CAN_RD: begin
					state_q <= S_CAN_CMP;
				end
				S_CAN_CMP: begin
					// Matching entries are dropped; the rest slide down to the kept position.
					if (key_match) begin
						removed_q <= removed_q + 1'b1;
					end else begin
						kept_q <= kept_q + 1'b1;
					end
					walk_i_q <= walk_i_q + 1'b1;
					if (walk_i_q + 1'b1 == count_q[lvl]) begin
						count_q[lvl] <= key_match ? kept_q : kept_q + 1'b1;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_CAN_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request word, taken tag and the output word.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q     <= req.data;
			res_tag_q <= '0;
		end
		if (state_q == S_TAKE_RD) begin
			res_tag_q <= ram_rdata[SLOT_W-1:KEY_W];
		end
		if (state_q == S_DONE && out_free) begin
			out_q.taken_valid    <= res_valid_q;
			out_q.taken_tag      <= res_tag_q;
			out_q.taken_level    <= 2'(res_level_q);
			out_q.removed_count  <= 5'(removed_q);
			out_q.insert_dropped <= res_drop_q;
			out_q.any_queued     <= any_queued;
		end
	end

	// No level ever holds more entries than its ring has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!count_over)
		else $error("level count exceeds ring depth");

	// During a cancel walk every visited entry is either kept or removed.
	a_walk_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CAN_RD || state_q == S_CAN_CMP) |->
		(CNT_W'(kept_q + removed_q) == walk_i_q))
		else $error("cancel walk lost track of entries");

	// A taken result never reports cancel or insert outcomes.
	a_take_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.taken_valid) |->
		(res.data.removed_count == '0 && !res.data.insert_dropped))
		else $error("taken result carries another mode's status");
endmodule

// ----- tb/multi_priority_request_deque_top_tb.sv -----
// Self-checking testbench for the multi-priority request deque top level.
// Depends on mprd_pkg, mprd_req_if, mprd_res_if and the design under test;
// a shadow copy of every priority level predicts each result word.
module multi_priority_request_deque_top_tb;
	import mprd_pkg::*;

	// One queued request as the shadow copy holds it.
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] key;
	} entry_t;

	// A request word waiting to be sent, with an optional hold until every earlier result has come back.
	typedef struct packed {
		req_t word;
		bit   wait_drain;
	} pending_t;

	logic clk;
	logic arst_n;

	mprd_req_if req_ch ();
	mprd_res_if res_ch ();

	multi_priority_request_deque_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	pending_t pending_words[$];
	res_t     expected_results[$];
	entry_t   shadow_levels[PRIORITY_LEVELS][$];
	int       mismatch_cnt = 0;
	int       sent_cnt     = 0;
	int       send_gap;
	int       stall_left;
	int       random_cnt;
	bit       quiet;

	// Every third stretch of 40 words runs with no gaps on either side.
	assign quiet = ((sent_cnt / 40) % 3) == 2;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap length: mostly none, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// Keys come mostly from a small pool so that cancels find matches.
	function automatic logic [15:0] pick_key();
		if ($urandom_range(0, 99) < 75) begin
			return 16'($urandom_range(0, 3));
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic void queue_request(input mode_t mode, input int lvl,
			input logic [15:0] tag, input logic [15:0] key, input bit wait_drain);
		pending_t p;
		p.word.mode        = mode;
		p.word.level       = 2'(lvl);
		p.word.request_tag = tag;
		p.word.request_key = key;
		p.wait_drain       = wait_drain;
		pending_words.push_back(p);
	endfunction

	// Applies one accepted request word to the shadow levels and returns its result word.
	function automatic res_t apply_to_shadow(input req_t r);
		res_t   o;
		entry_t e;
		entry_t kept[$];
		int     lv;
		int     removed;
		bit     found;
		o       = '0;
		lv      = int'(r.level);
		removed = 0;
		found   = 1'b0;
		case (r.mode) inside
			MODE_TAIL, MODE_HEAD: begin
				e.tag = r.request_tag;
				e.key = r.request_key;
				if (lv >= PRIORITY_LEVELS || shadow_levels[lv].size() >= LEVEL_DEPTH) begin
					o.insert_dropped = 1'b1;
				end else if (r.mode == MODE_TAIL) begin
					shadow_levels[lv].push_back(e);
				end else begin
					shadow_levels[lv].push_front(e);
				end
			end
			MODE_TAKE: begin
				for (int i = 0; i < PRIORITY_LEVELS; i++) begin
					if (!found && shadow_levels[i].size() != 0) begin
						e             = shadow_levels[i].pop_front();
						o.taken_valid = 1'b1;
						o.taken_tag   = e.tag;
						o.taken_level = 2'(i);
						found         = 1'b1;
					end
				end
			end
			default: begin
				// Cancel keeps the order of the entries that survive.
				if (lv < PRIORITY_LEVELS) begin
					for (int i = 0; i < shadow_levels[lv].size(); i++) begin
						if (shadow_levels[lv][i].key == r.request_key) begin
							removed++;
						end else begin
							kept.push_back(shadow_levels[lv][i]);
						end
					end
					shadow_levels[lv] = kept;
				end
				o.removed_count = 5'(removed);
			end
		endcase
		for (int i = 0; i < PRIORITY_LEVELS; i++) begin
			if (shadow_levels[i].size() != 0) begin
				o.any_queued = 1'b1;
			end
		end
		return o;
	endfunction

	// Compares one result word with the oldest prediction.
	function automatic void check_result(input res_t got);
		res_t want;
		if (expected_results.size() == 0) begin
			$error("result word arrived with no request outstanding");
			mismatch_cnt++;
			return;
		end
		want = expected_results.pop_front();
		if (got.taken_valid !== want.taken_valid) begin
			$error("taken_valid: expected %0d, got %0d", want.taken_valid, got.taken_valid);
			mismatch_cnt++;
		end
		if (got.taken_tag !== want.taken_tag) begin
			$error("taken_tag: expected %0h, got %0h", want.taken_tag, got.taken_tag);
			mismatch_cnt++;
		end
		if (got.taken_level !== want.taken_level) begin
			$error("taken_level: expected %0d, got %0d", want.taken_level, got.taken_level);
			mismatch_cnt++;
		end
		if (got.removed_count !== want.removed_count) begin
			$error("removed_count: expected %0d, got %0d", want.removed_count,
				got.removed_count);
			mismatch_cnt++;
		end
		if (got.insert_dropped !== want.insert_dropped) begin
			$error("insert_dropped: expected %0d, got %0d", want.insert_dropped,
				got.insert_dropped);
			mismatch_cnt++;
		end
		if (got.any_queued !== want.any_queued) begin
			$error("any_queued: expected %0d, got %0d", want.any_queued, got.any_queued);
			mismatch_cnt++;
		end
	endfunction

	// Driver: predicts each accepted word and offers the next one after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(apply_to_shadow(req_ch.data));
				sent_cnt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].wait_drain && expected_results.size() != 0)) begin
					req_ch.data  <= pending_words[0].word;
					req_ch.valid <= 1'b1;
					pending_words.pop_front();
					send_gap = quiet ? 0 : pick_gap();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result word and stalls ready at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				check_result(res_ch.data);
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				res_ch.ready <= (stall_left == 0);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int lv;
		int n;
		int r;
		logic [15:0] key;

		// Empty deque: take and cancel find nothing.
		queue_request(MODE_TAKE, 2, 16'h1357, 16'h2468, 1'b0);
		queue_request(MODE_CANCEL, 0, 16'h0000, 16'h0000, 1'b0);
		// Inserts with extreme tags and keys, at both ends of a level.
		queue_request(MODE_TAIL, 0, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_request(MODE_HEAD, 3, 16'h0000, 16'h0000, 1'b0);
		queue_request(MODE_TAIL, 1, 16'h1234, 16'h0005, 1'b0);
		queue_request(MODE_HEAD, 1, 16'hAAAA, 16'h0005, 1'b0);
		queue_request(MODE_TAIL, 1, 16'h5555, 16'h0007, 1'b0);
		// Take serves level 0 first; cancel removes two and keeps the rest in order.
		queue_request(MODE_TAKE, 3, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_request(MODE_CANCEL, 1, 16'hFFFF, 16'h0005, 1'b0);
		// Fill level 2 from both ends, overflow it, then cancel all sixteen at once.
		for (int i = 0; i < LEVEL_DEPTH; i++) begin
			queue_request((i % 2) ? MODE_HEAD : MODE_TAIL, 2, 16'($urandom_range(0, 65535)),
				16'h00C3, 1'b0);
		end
		queue_request(MODE_HEAD, 2, 16'hBEEF, 16'h00C3, 1'b0);
		queue_request(MODE_CANCEL, 2, 16'h0000, 16'h00C3, 1'b0);

		// Random part: single operations mixed with fill, drain and cancel bursts.
		random_cnt = 0;
		while (random_cnt < 400) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				n = $urandom_range(0, 99);
				queue_request((n < 30) ? MODE_TAIL : (n < 50) ? MODE_HEAD :
					(n < 80) ? MODE_TAKE : MODE_CANCEL,
					$urandom_range(0, 3), 16'($urandom_range(0, 65535)), pick_key(),
					random_cnt == 0 || $urandom_range(0, 99) < 3);
				random_cnt++;
			end else if (r < 85) begin
				lv  = $urandom_range(0, 3);
				key = pick_key();
				n   = $urandom_range(10, 20);
				for (int i = 0; i < n; i++) begin
					queue_request($urandom_range(0, 1) ? MODE_HEAD : MODE_TAIL, lv,
						16'($urandom_range(0, 65535)),
						($urandom_range(0, 3) == 0) ? pick_key() : key, 1'b0);
				end
				random_cnt += n;
			end else if (r < 95) begin
				n = $urandom_range(5, 20);
				for (int i = 0; i < n; i++) begin
					queue_request(MODE_TAKE, $urandom_range(0, 3),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
				end
				random_cnt += n;
			end else begin
				key = pick_key();
				for (int i = 0; i < PRIORITY_LEVELS; i++) begin
					queue_request(MODE_CANCEL, i, 16'($urandom_range(0, 65535)), key, 1'b0);
				end
				random_cnt += PRIORITY_LEVELS;
			end
		end

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);

		if (mismatch_cnt == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
